FILE: rtl/hmr_pkg.sv
package hmr_pkg;

  localparam int STORE_DEPTH   = 11;
  localparam int METHOD_COUNT  = 33;
  localparam int LEN_W         = 4;
  localparam int CODE_W        = 6;

  localparam logic [LEN_W-1:0]  TOKEN_MIN_LEN = 4'd3;
  localparam logic [LEN_W-1:0]  TOKEN_MAX_LEN = 4'd13;
  localparam logic [LEN_W-1:0]  LEN_SATURATE  = 4'd15;
  localparam logic [LEN_W-1:0]  STORE_LIMIT   = 4'd11;
  localparam logic [CODE_W-1:0] CODE_UNKNOWN  = 6'd0;

  typedef logic [8*STORE_DEPTH-1:0] token_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    token_word_t      text;
  } keyword_t;

  // Keyword text is right-justified: the last character sits in the lowest byte.
  localparam keyword_t KW_TABLE [METHOD_COUNT] = '{
    '{4'd3,  "ACL"},        '{4'd4,  "BIND"},       '{4'd8,  "CHECKOUT"},
    '{4'd7,  "CONNECT"},    '{4'd4,  "COPY"},       '{4'd6,  "DELETE"},
    '{4'd3,  "GET"},        '{4'd4,  "HEAD"},       '{4'd4,  "LINK"},
    '{4'd4,  "LOCK"},       '{4'd8,  "M-SEARCH"},   '{4'd5,  "MERGE"},
    '{4'd10, "MKACTIVITY"}, '{4'd10, "MKCALENDAR"}, '{4'd5,  "MKCOL"},
    '{4'd4,  "MOVE"},       '{4'd6,  "NOTIFY"},     '{4'd7,  "OPTIONS"},
    '{4'd5,  "PATCH"},      '{4'd4,  "POST"},       '{4'd8,  "PROPFIND"},
    '{4'd9,  "PROPPATCH"},  '{4'd5,  "PURGE"},      '{4'd3,  "PUT"},
    '{4'd6,  "REBIND"},     '{4'd6,  "REPORT"},     '{4'd6,  "SEARCH"},
    '{4'd9,  "SUBSCRIBE"},  '{4'd5,  "TRACE"},      '{4'd6,  "UNBIND"},
    '{4'd6,  "UNLINK"},     '{4'd6,  "UNLOCK"},     '{4'd11, "UNSUBSCRIBE"}
  };

  // The token word holds the first byte in the lowest bits.
  function automatic logic [CODE_W-1:0] method_lookup(input token_word_t bytes,
                                                      input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] code;
    logic              hit;
    int                klen;
    code = CODE_UNKNOWN;
    for (int m = 0; m < METHOD_COUNT; m++) begin
      klen = int'(KW_TABLE[m].len);
      hit  = (len == KW_TABLE[m].len);
      for (int i = 0; i < STORE_DEPTH; i++) begin
        if (i < klen) begin
          if (bytes[8*i +: 8] != KW_TABLE[m].text[8*(klen-1-i) +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit && (code == CODE_UNKNOWN)) begin
        code = CODE_W'(m + 1);
      end
    end
    if ((len < TOKEN_MIN_LEN) || (len > TOKEN_MAX_LEN)) begin
      code = CODE_UNKNOWN;
    end
    return code;
  endfunction

endpackage

FILE: rtl/http_method_recognizer.sv
// The final byte loads the classify stage; the code moves on when the output is free.
// Throughput: one byte per cycle when not stalled; one result per token, back to back.
// The byte store and a one-entry classify stage sit in front of the output register.
// Reset (rst_n low, synchronous) clears the length count and all valid flags.
// The byte store and payload registers are not reset.
module http_method_recognizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] token_byte
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [5:0] method_code, [7:6] zero
);
  import hmr_pkg::*;

  logic [7:0]        seen_bytes_r [STORE_DEPTH];
  logic [LEN_W-1:0]  token_length_r;
  logic [LEN_W-1:0]  token_length_inc;
  token_word_t       snap_nxt;
  token_word_t       snap_r;
  logic [LEN_W-1:0]  cls_len_r;
  logic              cls_valid_r;
  logic              out_valid_r;
  logic [CODE_W-1:0] code_r;
  logic              in_acc;
  logic              out_free;
  logic              cls_adv;

  assign out_free  = !out_valid_r || out_tready;
  assign cls_adv   = cls_valid_r && out_free;
  assign in_tready = !cls_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign token_length_inc = (token_length_r == LEN_SATURATE) ? token_length_r
                                                             : token_length_r + 1'b1;

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      snap_nxt[8*i +: 8] = (LEN_W'(i) == token_length_r) ? in_tdata : seen_bytes_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_length_r <= '0;
      cls_valid_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        token_length_r <= in_tlast ? '0 : token_length_inc;
      end
      if (in_acc && in_tlast) begin
        cls_valid_r <= 1'b1;
      end else if (cls_adv) begin
        cls_valid_r <= 1'b0;
      end
      if (cls_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (token_length_r < STORE_LIMIT)) begin
      seen_bytes_r[token_length_r] <= in_tdata;
    end
    if (in_acc && in_tlast) begin
      snap_r    <= snap_nxt;
      cls_len_r <= token_length_inc;
    end
    if (cls_adv) begin
      code_r <= method_lookup(snap_r, cls_len_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, code_r};

  a_last_clears_length: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (token_length_r == '0))
    else $error("length count not cleared after final byte");

  a_last_loads_classify: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> cls_valid_r)
    else $error("final byte did not load the classify stage");

  a_code_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (code_r <= CODE_W'(METHOD_COUNT)))
    else $error("method code out of range");

  a_classify_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cls_adv |=> out_valid_r)
    else $error("classified token did not reach the output register");

endmodule

FILE: sim/http_method_recognizer_tb.sv
`timescale 1ns / 100ps

module http_method_recognizer_tb;
  import hmr_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_BYTES     = 280;
  localparam int LONG_HOLD        = 90;
  localparam int BURST_TOKENS     = 15;
  localparam int FROM_PREDICTOR   = -1;
  localparam int CODE_ACL         = 1;
  localparam int CODE_UNSUBSCRIBE = 33;
  localparam int DIRECTED_COUNT   = 13;

  typedef logic [7:0] byte_q_t [$];

  typedef struct {
    int unsigned     len;
    logic [8*20-1:0] text;
    int              code;
  } token_vector_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;    // [7:0] token_byte
  logic       in_tlast = 1'b0;  // final_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;        // [5:0] method_code, [7:6] zero

  string method_name [1:METHOD_COUNT] = '{
    "ACL", "BIND", "CHECKOUT", "CONNECT", "COPY", "DELETE", "GET", "HEAD", "LINK",
    "LOCK", "M-SEARCH", "MERGE", "MKACTIVITY", "MKCALENDAR", "MKCOL", "MOVE",
    "NOTIFY", "OPTIONS", "PATCH", "POST", "PROPFIND", "PROPPATCH", "PURGE", "PUT",
    "REBIND", "REPORT", "SEARCH", "SUBSCRIBE", "TRACE", "UNBIND", "UNLINK",
    "UNLOCK", "UNSUBSCRIBE"
  };

  // The text is right-justified, so the first byte of a token sits highest.
  token_vector_t directed_tokens [DIRECTED_COUNT] = '{
    '{1,  "A",                 CODE_UNKNOWN},
    '{2,  "GE",                CODE_UNKNOWN},
    '{3,  "ACL",               CODE_ACL},
    '{11, "UNSUBSCRIBE",       CODE_UNSUBSCRIBE},
    '{4,  "PUTS",              FROM_PREDICTOR},
    '{3,  "get",               FROM_PREDICTOR},
    '{3,  24'h47_00_54,        FROM_PREDICTOR},
    '{3,  24'hFF_FF_FF,        FROM_PREDICTOR},
    '{2,  16'h00_00,           CODE_UNKNOWN},
    '{12, "UNSUBSCRIBES",      FROM_PREDICTOR},
    '{13, "PROPPATCHPOST",     FROM_PREDICTOR},
    '{17, "UNSUBSCRIBEUNLOCK", CODE_UNKNOWN},
    '{8,  "M-SEARCH",          FROM_PREDICTOR}
  };

  logic [7:0]        seen_bytes [STORE_DEPTH];
  logic [LEN_W-1:0]  seen_len = '0;
  logic [CODE_W-1:0] expected_codes [$];
  logic [CODE_W-1:0] wanted_code;
  int                mismatches = 0;
  int                cycle_count = 0;
  bit                sender_gaps = 1'b1;
  bit                burst_mode = 1'b0;
  bit                long_hold_req = 1'b0;

  http_method_recognizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [CODE_W-1:0] classify_token();
    logic [CODE_W-1:0] code;
    int                n;
    bit                same;
    code = CODE_UNKNOWN;
    n = int'(seen_len);
    if ((seen_len >= TOKEN_MIN_LEN) && (seen_len <= TOKEN_MAX_LEN)) begin
      for (int m = 1; m <= METHOD_COUNT; m++) begin
        if (method_name[m].len() == n) begin
          same = 1'b1;
          for (int i = 0; i < n; i++) begin
            if (seen_bytes[i] != method_name[m][i]) begin
              same = 1'b0;
            end
          end
          if (same && (code == CODE_UNKNOWN)) begin
            code = CODE_W'(m);
          end
        end
      end
    end
    return code;
  endfunction

  function automatic byte_q_t spell_method(input int m);
    byte_q_t q;
    for (int i = 0; i < method_name[m].len(); i++) begin
      q.push_back(method_name[m][i]);
    end
    return q;
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic last, input int forced);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (seen_len < STORE_LIMIT) begin
      seen_bytes[seen_len] = value;
    end
    if (seen_len != LEN_SATURATE) begin
      seen_len = seen_len + 1'b1;
    end
    if (last) begin
      expected_codes.push_back((forced == FROM_PREDICTOR) ? classify_token()
                                                          : CODE_W'(forced));
      seen_len = '0;
    end
    @(negedge clk);
  endtask

  task automatic send_token(input byte_q_t bytes, input int forced);
    sender_gaps = burst_mode ? 1'b0 : ($urandom_range(0, 3) != 0);
    foreach (bytes[i]) begin
      send_byte(bytes[i], i == bytes.size() - 1, forced);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_codes.size() == 0) begin
        $error("method_code: expected none, actual %0d", out_tdata[CODE_W-1:0]);
        mismatches++;
      end else begin
        wanted_code = expected_codes.pop_front();
        if (out_tdata[CODE_W-1:0] !== wanted_code) begin
          $error("method_code: expected %0d, actual %0d", wanted_code,
                 out_tdata[CODE_W-1:0]);
          mismatches++;
        end
        if (out_tdata[7:CODE_W] !== '0) begin
          $error("tdata padding: expected 0, actual %0d", out_tdata[7:CODE_W]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int stall;
    bit stalls_on;
    stalls_on = 1'b1;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        if ($urandom_range(0, 15) == 0) begin
          stalls_on = !stalls_on;
        end
        stall = stalls_on ? $urandom_range(0, 12) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    byte_q_t token;
    int      total;
    int      kind;
    int      pos;
    int      n;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_tokens[t]) begin
      token.delete();
      for (int i = 0; i < directed_tokens[t].len; i++) begin
        token.push_back(directed_tokens[t].text[8*(directed_tokens[t].len-1-i) +: 8]);
      end
      send_token(token, directed_tokens[t].code);
    end

    // The output is held off while whole methods stream in back to back.
    burst_mode = 1'b1;
    long_hold_req = 1'b1;
    repeat (BURST_TOKENS) begin
      send_token(spell_method($urandom_range(1, METHOD_COUNT)), FROM_PREDICTOR);
    end
    burst_mode = 1'b0;
    in_tvalid <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    @(negedge clk);

    total = 0;
    while (total < RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      token = spell_method($urandom_range(1, METHOD_COUNT));
      if (kind < 60) begin
      end else if (kind < 70) begin
        pos = $urandom_range(0, token.size() - 1);
        token[pos] = token[pos] ^ 8'(1 << $urandom_range(0, 7));
      end else if (kind < 78) begin
        repeat ($urandom_range(1, 4)) token.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 84) begin
        void'(token.pop_back());
      end else if (kind < 88) begin
        foreach (token[i]) begin
          if ((token[i] >= "A") && (token[i] <= "Z")) begin
            token[i] = token[i] | 8'h20;
          end
        end
      end else begin
        token.delete();
        n = $urandom_range(1, 20);
        repeat (n) begin
          token.push_back($urandom_range(0, 1) ? 8'($urandom_range(65, 90))
                                                : 8'($urandom_range(0, 255)));
        end
      end
      total += token.size();
      send_token(token, FROM_PREDICTOR);
    end
    in_tvalid <= 1'b0;

    while (expected_codes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
